>>> hw/rtl/pthc_pkg.sv
// ----------------------------------------------------------------------------
// pthc_pkg: shared types and constants of the sensor compensation pipeline
// Holds the register indexes, the divider geometry and the word of side data
// that travels through the pipelined divider next to each quotient.
// ----------------------------------------------------------------------------
package pthc_pkg;

   localparam int DIV_W      = 64;
   localparam int DIV_STAGES = 64;

   typedef enum logic [2:0] {
      CSR_TEMP_CAL   = 3'd0,
      CSR_PRES_CAL_A = 3'd1,
      CSR_PRES_CAL_B = 3'd2,
      CSR_PRES_CAL_C = 3'd3,
      CSR_HUM_CAL    = 3'd4
   } csr_index_type;

   // Everything a word still needs once its quotient leaves the divider.
   typedef struct packed {
      logic        quot_neg;
      logic        div_zero;
      logic [18:0] temp_centi;
      logic [16:0] humidity;
   } div_side_type;

   localparam logic signed [33:0] PRES_TEMP_OFFSET = 34'sd128000;
   localparam logic signed [31:0] HUM_TEMP_OFFSET  = 32'sd76800;
   localparam logic        [31:0] HUM_MAX          = 32'd419430400;
   localparam logic        [63:0] PRES_BASE        = 64'd1048576;
   localparam logic        [63:0] PRES_SCALE       = 64'd3125;

endpackage

>>> hw/rtl/pthc_div.sv
// ----------------------------------------------------------------------------
// pthc_div: pipelined unsigned 64-bit restoring divider
// One quotient bit per stage, one new division may enter every cycle.
// ----------------------------------------------------------------------------
module pthc_div
   import pthc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [DIV_W-1:0]   in_dividend,
   input  logic [DIV_W-1:0]   in_divisor,
   input  div_side_type       in_side,
   output logic               out_valid,
   output logic [DIV_W-1:0]   out_quotient,
   output div_side_type       out_side
);

   logic [DIV_W-1:0]      rem_ff  [DIV_STAGES];
   logic [DIV_W-1:0]      quo_ff  [DIV_STAGES];
   logic [DIV_W-1:0]      dsr_ff  [DIV_STAGES];
   div_side_type          side_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] vld_ff;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_W-1:0] rem_prev;
      logic [DIV_W-1:0] quo_prev;
      logic [DIV_W-1:0] dsr_prev;
      div_side_type     side_prev;
      logic             vld_prev;
      logic [DIV_W:0]   trial;
      logic [DIV_W:0]   diff;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign quo_prev  = in_dividend;
         assign dsr_prev  = in_divisor;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign dsr_prev  = dsr_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      assign trial = {rem_prev, quo_prev[DIV_W-1]};
      assign diff  = trial - {1'b0, dsr_prev};

      always_ff @(posedge clock) begin
         rem_ff[k]  <= diff[DIV_W] ? trial[DIV_W-1:0] : diff[DIV_W-1:0];
         quo_ff[k]  <= {quo_prev[DIV_W-2:0], ~diff[DIV_W]};
         dsr_ff[k]  <= dsr_prev;
         side_ff[k] <= side_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prev;
         end
      end
   end

   assign out_valid    = vld_ff[DIV_STAGES-1];
   assign out_quotient = quo_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

>>> hw/rtl/pth_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation_top: temperature, pressure and humidity compensation
// Turns one raw sensor triple into compensated fixed-point readings.
// ----------------------------------------------------------------------------
// Usage:
// A raw word (temperature, pressure, humidity) is taken at a rising edge with
// start high and busy low. busy never rises, so a new word may be offered in
// every cycle. Each result word appears for exactly one cycle with rsp_valid
// high, after its raw word has passed through every stage below; results
// leave in the order the raw words came in, one per cycle at most.
// The pipeline is made of ten front stages (temperature, the 64-bit pressure
// products in 34x34 and 64x16 slices, and the humidity chain), the 64-stage
// divider that yields one quotient bit per stage, and four back stages (sign
// restore, the two correction-term stages and the result register).
// Calibration words are written through the csr_ port at any idle time;
// each write takes effect at once. Indexes outside the list are ignored.
// Reset clears all calibration words and drops every word in flight; the
// block accepts new words in the first cycle after reset. The receiver cannot
// stall the result port, so nothing is ever held back.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_top
   import pthc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_raw_temperature,
   input  logic [19:0] req_raw_pressure,
   input  logic [15:0] req_raw_humidity,
   output logic        rsp_valid,
   output logic signed [18:0] rsp_temperature_centi,
   output logic [31:0] rsp_pressure_q24_8,
   output logic        rsp_pressure_divisor_zero,
   output logic [16:0] rsp_humidity_q22_10,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // ------------------------------------------------------------------------
   // Calibration registers and the coefficients unpacked from them.
   // ------------------------------------------------------------------------
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_pres_a_ff;
   logic [63:0] cal_pres_b_ff;
   logic [15:0] cal_pres_c_ff;
   logic [63:0] cal_hum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff   <= '0;
         cal_pres_a_ff <= '0;
         cal_pres_b_ff <= '0;
         cal_pres_c_ff <= '0;
         cal_hum_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_CAL:   cal_temp_ff   <= csr_wdata[47:0];
            CSR_PRES_CAL_A: cal_pres_a_ff <= csr_wdata;
            CSR_PRES_CAL_B: cal_pres_b_ff <= csr_wdata;
            CSR_PRES_CAL_C: cal_pres_c_ff <= csr_wdata[15:0];
            CSR_HUM_CAL:    cal_hum_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic        [31:0] t1;
   logic signed [31:0] t2, t3;
   logic        [15:0] p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic        [31:0] h1, h3;
   logic signed [31:0] h2, h4, h5, h6;

   assign t1 = {16'd0, cal_temp_ff[15:0]};
   assign t2 = {{16{cal_temp_ff[31]}}, cal_temp_ff[31:16]};
   assign t3 = {{16{cal_temp_ff[47]}}, cal_temp_ff[47:32]};
   assign p1 = cal_pres_a_ff[15:0];
   assign p2 = cal_pres_a_ff[31:16];
   assign p3 = cal_pres_a_ff[47:32];
   assign p4 = cal_pres_a_ff[63:48];
   assign p5 = cal_pres_b_ff[15:0];
   assign p6 = cal_pres_b_ff[31:16];
   assign p7 = cal_pres_b_ff[47:32];
   assign p8 = cal_pres_b_ff[63:48];
   assign p9 = cal_pres_c_ff;
   assign h1 = {24'd0, cal_hum_ff[7:0]};
   assign h2 = {{16{cal_hum_ff[23]}}, cal_hum_ff[23:8]};
   assign h3 = {24'd0, cal_hum_ff[31:24]};
   assign h4 = {{20{cal_hum_ff[43]}}, cal_hum_ff[43:32]};
   assign h5 = {{20{cal_hum_ff[55]}}, cal_hum_ff[55:44]};
   assign h6 = {{24{cal_hum_ff[63]}}, cal_hum_ff[63:56]};

   // The block is ready for a new word in every cycle.
   assign busy = 1'b0;

   // Valid bits of the front stages 1..10 and of the back stages 11..14.
   logic [9:0] front_vld_ff;
   logic [3:0] back_vld_ff;
   logic       div_out_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= '0;
         back_vld_ff  <= '0;
      end else begin
         front_vld_ff <= {front_vld_ff[8:0], start & ~busy};
         back_vld_ff  <= {back_vld_ff[2:0], div_out_vld};
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: the two temperature products.
   // ------------------------------------------------------------------------
   logic [31:0] st1_a_diff, st1_d, s1_a_in, s1_dd_in;
   logic [31:0] s1_a_ff, s1_dd_ff;
   logic [19:0] s1_rawp_ff;
   logic [15:0] s1_rawh_ff;

   assign st1_a_diff = {15'd0, req_raw_temperature[19:3]} - (t1 << 1);
   assign s1_a_in    = st1_a_diff * t2;
   assign st1_d      = {16'd0, req_raw_temperature[19:4]} - t1;
   assign s1_dd_in   = st1_d * st1_d;

   always_ff @(posedge clock) begin
      s1_a_ff    <= s1_a_in;
      s1_dd_ff   <= s1_dd_in;
      s1_rawp_ff <= req_raw_pressure;
      s1_rawh_ff <= req_raw_humidity;
   end

   // ------------------------------------------------------------------------
   // Stage 2: scale the first term, multiply the square by T3.
   // ------------------------------------------------------------------------
   logic signed [31:0] s2_a_in, st2_dd_sh, s2_b_in;
   logic signed [31:0] s2_a_ff, s2_b_ff;
   logic [19:0] s2_rawp_ff;
   logic [15:0] s2_rawh_ff;

   assign s2_a_in   = $signed(s1_a_ff) >>> 11;
   assign st2_dd_sh = $signed(s1_dd_ff) >>> 12;
   assign s2_b_in   = st2_dd_sh * t3;

   always_ff @(posedge clock) begin
      s2_a_ff    <= s2_a_in;
      s2_b_ff    <= s2_b_in;
      s2_rawp_ff <= s1_rawp_ff;
      s2_rawh_ff <= s1_rawh_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 3: the fine temperature term.
   // ------------------------------------------------------------------------
   logic signed [31:0] st3_b_sh, s3_tf_in, s3_tf_ff;
   logic [19:0] s3_rawp_ff;
   logic [15:0] s3_rawh_ff;

   assign st3_b_sh = s2_b_ff >>> 14;
   assign s3_tf_in = s2_a_ff + st3_b_sh;

   always_ff @(posedge clock) begin
      s3_tf_ff   <= s3_tf_in;
      s3_rawp_ff <= s2_rawp_ff;
      s3_rawh_ff <= s2_rawh_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 4: temperature result with saturation, offsets for the other paths.
   // ------------------------------------------------------------------------
   logic signed [31:0] st4_tc_mul, st4_tc;
   logic        [18:0] s4_tc_in;
   logic signed [33:0] s4_v1_in, s4_v1_ff;
   logic signed [31:0] s4_vh_in, s4_vh_ff;
   logic [18:0] s4_tc_ff;
   logic [19:0] s4_rawp_ff;
   logic [15:0] s4_rawh_ff;

   assign st4_tc_mul = s3_tf_ff * 32'sd5 + 32'sd128;
   assign st4_tc     = st4_tc_mul >>> 8;
   assign s4_v1_in   = {{2{s3_tf_ff[31]}}, s3_tf_ff} - PRES_TEMP_OFFSET;
   assign s4_vh_in   = s3_tf_ff - HUM_TEMP_OFFSET;

   always_comb begin
      if (st4_tc < -32'sd262144) begin
         s4_tc_in = 19'h40000;
      end else if (st4_tc > 32'sd262143) begin
         s4_tc_in = 19'h3FFFF;
      end else begin
         s4_tc_in = st4_tc[18:0];
      end
   end

   always_ff @(posedge clock) begin
      s4_tc_ff   <= s4_tc_in;
      s4_v1_ff   <= s4_v1_in;
      s4_vh_ff   <= s4_vh_in;
      s4_rawp_ff <= s3_rawp_ff;
      s4_rawh_ff <= s3_rawh_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 5: square of the pressure offset, first humidity products.
   // ------------------------------------------------------------------------
   logic signed [67:0] st5_vv_full;
   logic signed [49:0] s5_vp5_in, s5_vp2_in, s5_vp5_ff, s5_vp2_ff;
   logic        [63:0] s5_vv_ff;
   logic signed [31:0] st5_hx_sum, s5_hx_in, st5_hy1_mul, s5_hy1_in;
   logic signed [31:0] st5_hy2_mul, st5_hy2_sh, s5_hy2_in;
   logic signed [31:0] s5_hx_ff, s5_hy1_ff, s5_hy2_ff;
   logic [18:0] s5_tc_ff;
   logic [19:0] s5_rawp_ff;

   assign st5_vv_full = 68'(s4_v1_ff) * 68'(s4_v1_ff);
   assign s5_vp5_in   = 50'(s4_v1_ff) * 50'(p5);
   assign s5_vp2_in   = 50'(s4_v1_ff) * 50'(p2);

   assign st5_hx_sum  = ({16'd0, s4_rawh_ff} << 14) - (h4 << 20) - h5 * s4_vh_ff + 32'sd16384;
   assign s5_hx_in    = st5_hx_sum >>> 15;
   assign st5_hy1_mul = s4_vh_ff * h6;
   assign s5_hy1_in   = st5_hy1_mul >>> 10;
   assign st5_hy2_mul = s4_vh_ff * h3;
   assign st5_hy2_sh  = st5_hy2_mul >>> 11;
   assign s5_hy2_in   = st5_hy2_sh + 32'sd32768;

   always_ff @(posedge clock) begin
      s5_vv_ff   <= st5_vv_full[63:0];
      s5_vp5_ff  <= s5_vp5_in;
      s5_vp2_ff  <= s5_vp2_in;
      s5_hx_ff   <= s5_hx_in;
      s5_hy1_ff  <= s5_hy1_in;
      s5_hy2_ff  <= s5_hy2_in;
      s5_tc_ff   <= s4_tc_ff;
      s5_rawp_ff <= s4_rawp_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 6: square times P6 and P3, humidity product.
   // ------------------------------------------------------------------------
   logic signed [79:0] st6_v2a_full, st6_v1a_full;
   logic        [63:0] s6_v2a_ff, s6_v1a_ff;
   logic signed [49:0] s6_vp5_ff, s6_vp2_ff;
   logic signed [31:0] s6_hy_in, s6_hy_ff, s6_hx_ff;
   logic [18:0] s6_tc_ff;
   logic [19:0] s6_rawp_ff;

   assign st6_v2a_full = 80'($signed(s5_vv_ff)) * 80'(p6);
   assign st6_v1a_full = 80'($signed(s5_vv_ff)) * 80'(p3);
   assign s6_hy_in     = s5_hy1_ff * s5_hy2_ff;

   always_ff @(posedge clock) begin
      s6_v2a_ff  <= st6_v2a_full[63:0];
      s6_v1a_ff  <= st6_v1a_full[63:0];
      s6_vp5_ff  <= s5_vp5_ff;
      s6_vp2_ff  <= s5_vp2_ff;
      s6_hy_ff   <= s6_hy_in;
      s6_hx_ff   <= s5_hx_ff;
      s6_tc_ff   <= s5_tc_ff;
      s6_rawp_ff <= s5_rawp_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 7: sum the var2 terms, shape var1, humidity scale by H2.
   // ------------------------------------------------------------------------
   logic        [63:0] s7_v2_in, s7_v1b_in, s7_v2_ff, s7_v1b_ff;
   logic signed [63:0] st7_v1a_sh;
   logic signed [31:0] st7_hy_sh, st7_hy2, st7_hy3_mul, s7_hy_in;
   logic signed [31:0] s7_hy_ff, s7_hx_ff;
   logic [18:0] s7_tc_ff;
   logic [19:0] s7_rawp_ff;

   assign s7_v2_in   = s6_v2a_ff + ({{14{s6_vp5_ff[49]}}, s6_vp5_ff} << 17)
                       + ({{48{p4[15]}}, p4} << 35);
   assign st7_v1a_sh = $signed(s6_v1a_ff) >>> 8;
   assign s7_v1b_in  = st7_v1a_sh + ({{14{s6_vp2_ff[49]}}, s6_vp2_ff} << 12);

   assign st7_hy_sh   = s6_hy_ff >>> 10;
   assign st7_hy2     = st7_hy_sh + 32'sd2097152;
   assign st7_hy3_mul = st7_hy2 * h2 + 32'sd8192;
   assign s7_hy_in    = st7_hy3_mul >>> 14;

   always_ff @(posedge clock) begin
      s7_v2_ff   <= s7_v2_in;
      s7_v1b_ff  <= s7_v1b_in;
      s7_hy_ff   <= s7_hy_in;
      s7_hx_ff   <= s6_hx_ff;
      s7_tc_ff   <= s6_tc_ff;
      s7_rawp_ff <= s6_rawp_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 8: divisor product with P1, dividend base, humidity product.
   // ------------------------------------------------------------------------
   logic        [63:0] st8_v1_ofs, st8_pd, s8_num0_in, s8_v1c_ff, s8_num0_ff;
   logic signed [80:0] st8_v1c_full;
   logic signed [31:0] s8_hv_in, s8_hv_ff;
   logic [18:0] s8_tc_ff;

   assign st8_v1_ofs   = s7_v1b_ff + (64'd1 << 47);
   assign st8_v1c_full = 81'($signed(st8_v1_ofs)) * 81'($signed({1'b0, p1}));
   assign st8_pd       = PRES_BASE - {44'd0, s7_rawp_ff};
   assign s8_num0_in   = (st8_pd << 31) - s7_v2_ff;
   assign s8_hv_in     = s7_hx_ff * s7_hy_ff;

   always_ff @(posedge clock) begin
      s8_v1c_ff  <= st8_v1c_full[63:0];
      s8_num0_ff <= s8_num0_in;
      s8_hv_ff   <= s8_hv_in;
      s8_tc_ff   <= s7_tc_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 9: final dividend and divisor, humidity square.
   // ------------------------------------------------------------------------
   logic signed [63:0] s9_den_in, s9_den_ff;
   logic        [63:0] s9_num_in, s9_num_ff;
   logic signed [31:0] st9_hq, s9_hqq_in, s9_hqq_ff, s9_hv_ff;
   logic [18:0] s9_tc_ff;

   assign s9_den_in = $signed(s8_v1c_ff) >>> 33;
   assign s9_num_in = s8_num0_ff * PRES_SCALE;
   assign st9_hq    = s8_hv_ff >>> 15;
   assign s9_hqq_in = st9_hq * st9_hq;

   always_ff @(posedge clock) begin
      s9_den_ff <= s9_den_in;
      s9_num_ff <= s9_num_in;
      s9_hqq_ff <= s9_hqq_in;
      s9_hv_ff  <= s8_hv_ff;
      s9_tc_ff  <= s8_tc_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 10: magnitudes for the divider, humidity result with clamp.
   // ------------------------------------------------------------------------
   logic        [63:0] s10_an_in, s10_ad_in, s10_an_ff, s10_ad_ff;
   logic signed [31:0] st10_hqq_sh, st10_hsub_mul, st10_hsub_sh, st10_hv2;
   logic        [31:0] st10_hclamp;
   div_side_type       s10_side_in, s10_side_ff;

   assign s10_an_in = s9_num_ff[63] ? (64'd0 - s9_num_ff) : s9_num_ff;
   assign s10_ad_in = s9_den_ff[63] ? (64'd0 - s9_den_ff) : s9_den_ff;

   assign st10_hqq_sh   = s9_hqq_ff >>> 7;
   assign st10_hsub_mul = st10_hqq_sh * h1;
   assign st10_hsub_sh  = st10_hsub_mul >>> 4;
   assign st10_hv2      = s9_hv_ff - st10_hsub_sh;

   // Humidity is held inside 0 .. 100 %RH before the final scaling.
   always_comb begin
      if (st10_hv2[31]) begin
         st10_hclamp = '0;
      end else if (st10_hv2 > HUM_MAX) begin
         st10_hclamp = HUM_MAX;
      end else begin
         st10_hclamp = st10_hv2;
      end
   end

   assign s10_side_in.quot_neg   = s9_num_ff[63] ^ s9_den_ff[63];
   assign s10_side_in.div_zero   = (s9_den_ff == 64'sd0);
   assign s10_side_in.temp_centi = s9_tc_ff;
   assign s10_side_in.humidity   = st10_hclamp[28:12];

   always_ff @(posedge clock) begin
      s10_an_ff   <= s10_an_in;
      s10_ad_ff   <= s10_ad_in;
      s10_side_ff <= s10_side_in;
   end

   // ------------------------------------------------------------------------
   // Pipelined divider: one quotient bit per stage.
   // ------------------------------------------------------------------------
   logic [63:0]  div_quo;
   div_side_type div_side;

   pthc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (front_vld_ff[9]),
      .in_dividend  (s10_an_ff),
      .in_divisor   (s10_ad_ff),
      .in_side      (s10_side_ff),
      .out_valid    (div_out_vld),
      .out_quotient (div_quo),
      .out_side     (div_side)
   );

   // ------------------------------------------------------------------------
   // Stage 11: restore the quotient sign. The most negative dividend over
   // minus one wraps back to itself, as two's complement negation does.
   // ------------------------------------------------------------------------
   logic [63:0]  s11_p_ff;
   div_side_type s11_side_ff;

   always_ff @(posedge clock) begin
      s11_p_ff    <= div_side.quot_neg ? (64'd0 - div_quo) : div_quo;
      s11_side_ff <= div_side;
   end

   // ------------------------------------------------------------------------
   // Stage 12: square of p/2^13 in two 32-bit partial products, and P8 term.
   // The square only matters modulo 2^64: lo*lo + (hi*lo mod 2^31) << 33.
   // ------------------------------------------------------------------------
   logic signed [63:0] st12_ps, st12_w2_lo, s12_w2_in, s12_w2_ff;
   logic        [31:0] st12_ps_lo, st12_ps_hi, s12_sq_hl_in, s12_sq_hl_ff;
   logic        [63:0] s12_sq_ll_in, s12_sq_ll_ff, s12_p_ff;
   logic signed [79:0] st12_w2_full;
   div_side_type       s12_side_ff;

   assign st12_ps      = $signed(s11_p_ff) >>> 13;
   assign st12_ps_lo   = st12_ps[31:0];
   assign st12_ps_hi   = st12_ps[63:32];
   assign s12_sq_ll_in = 64'(st12_ps_lo) * 64'(st12_ps_lo);
   assign s12_sq_hl_in = st12_ps_hi * st12_ps_lo;
   assign st12_w2_full = 80'($signed(s11_p_ff)) * 80'(p8);
   assign st12_w2_lo   = st12_w2_full[63:0];
   assign s12_w2_in    = st12_w2_lo >>> 19;

   always_ff @(posedge clock) begin
      s12_sq_ll_ff <= s12_sq_ll_in;
      s12_sq_hl_ff <= s12_sq_hl_in;
      s12_w2_ff    <= s12_w2_in;
      s12_p_ff     <= s11_p_ff;
      s12_side_ff  <= s11_side_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 13: P9 term.
   // ------------------------------------------------------------------------
   logic        [63:0] st13_sq;
   logic signed [79:0] st13_w1_full;
   logic signed [63:0] st13_w1_lo, s13_w1_in, s13_w1_ff, s13_w2_ff;
   logic        [63:0] s13_p_ff;
   div_side_type       s13_side_ff;

   assign st13_sq      = s12_sq_ll_ff + {s12_sq_hl_ff[30:0], 33'd0};
   assign st13_w1_full = 80'($signed(st13_sq)) * 80'(p9);
   assign st13_w1_lo   = st13_w1_full[63:0];
   assign s13_w1_in    = st13_w1_lo >>> 25;

   always_ff @(posedge clock) begin
      s13_w1_ff   <= s13_w1_in;
      s13_w2_ff   <= s12_w2_ff;
      s13_p_ff    <= s12_p_ff;
      s13_side_ff <= s12_side_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 14: final pressure sum, saturation and the result register.
   // ------------------------------------------------------------------------
   logic signed [63:0] st14_sum, st14_sum_sh, st14_pf;
   logic        [31:0] st14_pres;
   logic signed [18:0] rsp_temp_ff;
   logic        [31:0] rsp_pres_ff;
   logic               rsp_zero_ff;
   logic        [16:0] rsp_hum_ff;

   assign st14_sum    = $signed(s13_p_ff) + s13_w1_ff + s13_w2_ff;
   assign st14_sum_sh = st14_sum >>> 8;
   assign st14_pf     = st14_sum_sh + ({{48{p7[15]}}, p7} << 4);

   // A zero divisor forces pressure to zero; otherwise clamp to 0 .. 2^32-1.
   always_comb begin
      if (s13_side_ff.div_zero || st14_pf[63]) begin
         st14_pres = '0;
      end else if (st14_pf[62:32] != '0) begin
         st14_pres = '1;
      end else begin
         st14_pres = st14_pf[31:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff <= s13_side_ff.temp_centi;
      rsp_pres_ff <= st14_pres;
      rsp_zero_ff <= s13_side_ff.div_zero;
      rsp_hum_ff  <= s13_side_ff.humidity;
   end

   assign rsp_valid                 = back_vld_ff[3];
   assign rsp_temperature_centi     = rsp_temp_ff;
   assign rsp_pressure_q24_8        = rsp_pres_ff;
   assign rsp_pressure_divisor_zero = rsp_zero_ff;
   assign rsp_humidity_q22_10       = rsp_hum_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A zero divisor must always come out as a zero pressure reading.
   a_zero_div_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressure_divisor_zero |-> rsp_pressure_q24_8 == 32'd0)
      else $error("pressure not forced to zero on zero divisor");

   // The humidity clamp keeps the result at or below 100 %RH.
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= 17'd102400)
      else $error("humidity result above full scale");

   // The zero flag handed to the divider matches the divisor magnitude.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      front_vld_ff[9] |-> (s10_side_ff.div_zero == (s10_ad_ff == 64'd0)))
      else $error("divisor zero flag out of step with divisor");

endmodule
